/* design/rfq_pkg.sv */
// ----------------------------------------------------------------------------
// rfq_pkg
// shared types and constants of the ready fifo and timer queue scheduler
// ----------------------------------------------------------------------------
package rfq_pkg;

  localparam int POOL_SLOTS = 128;
  localparam int IDX_W      = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int TASK_W     = 16;
  localparam int TIME_W     = 32;

  typedef enum logic [1:0] {
    REQ_POST_NOW = 2'd0,
    REQ_POST_DLY = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_POLL     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_FULL   = 3'd1,
    ST_READY  = 3'd2,
    ST_TIMER  = 3'd3,
    ST_IDLE   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_TAKE_RD, S_TAKE, S_WALK_RD, S_WALK_CHK,
    S_LINK_NEW, S_LINK_PREV, S_EMIT_ACC, S_EMIT_FULL, S_P_RD, S_P_LAT_R,
    S_P_LAT_T, S_FREE_R, S_EMIT_R, S_FREE_T, S_EMIT_T, S_EMIT_IDLE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_ACCEPT, OP_TICK, OP_TAKE_RD, OP_TAKE, OP_WALK_RD,
    OP_WALK_CHK, OP_LINK_NEW, OP_LINK_PREV, OP_P_RD, OP_P_LAT_R, OP_P_LAT_T,
    OP_FREE_R, OP_FREE_T, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t st;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    req_t req;
    logic pool_empty;
    logic ready_nonempty;
    logic walk_end;
    logic later;
    logic due;
    logic out_free;
  } stat_t;

endpackage

/* design/rfq_ram.sv */
// ----------------------------------------------------------------------------
// rfq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/rfq_ctrl.sv */
// ----------------------------------------------------------------------------
// rfq_ctrl
// sequencer of the scheduler: one request at a time through post, walk, poll
// ----------------------------------------------------------------------------
module rfq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rfq_pkg::stat_t stat,
  output rfq_pkg::cmd_t  cmd
);
  import rfq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:      if (stat.init_done) state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.req)
          REQ_TICK: state_nxt = S_IDLE;
          REQ_POLL: state_nxt = S_P_RD;
          default:  state_nxt = stat.pool_empty ? S_EMIT_FULL : S_TAKE_RD;
        endcase
      end
      S_TAKE_RD:   state_nxt = S_TAKE;
      S_TAKE:      state_nxt = (stat.req == REQ_POST_NOW) ? S_EMIT_ACC : S_WALK_RD;
      S_WALK_RD:   state_nxt = stat.walk_end ? S_LINK_NEW : S_WALK_CHK;
      S_WALK_CHK:  state_nxt = stat.later ? S_LINK_NEW : S_WALK_RD;
      S_LINK_NEW:  state_nxt = S_LINK_PREV;
      S_LINK_PREV: state_nxt = S_EMIT_ACC;
      S_P_RD:      state_nxt = S_P_LAT_R;
      S_P_LAT_R:   state_nxt = S_P_LAT_T;
      S_P_LAT_T: begin
        if (stat.ready_nonempty) state_nxt = S_FREE_R;
        else if (stat.due)       state_nxt = S_FREE_T;
        else                     state_nxt = S_EMIT_IDLE;
      end
      S_FREE_R:    state_nxt = S_EMIT_R;
      S_EMIT_R:    if (stat.out_free) state_nxt = stat.due ? S_FREE_T : S_IDLE;
      S_FREE_T:    state_nxt = S_EMIT_T;
      S_EMIT_ACC, S_EMIT_FULL, S_EMIT_T, S_EMIT_IDLE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '{op: OP_NONE, st: ST_ACCEPT, last: 1'b1};
    in_ready = 1'b0;
    case (state_r)
      S_INIT:      cmd.op = OP_INIT;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      S_DECODE:    if (stat.req == REQ_TICK) cmd.op = OP_TICK;
      S_TAKE_RD:   cmd.op = OP_TAKE_RD;
      S_TAKE:      cmd.op = OP_TAKE;
      S_WALK_RD:   if (!stat.walk_end) cmd.op = OP_WALK_RD;
      S_WALK_CHK:  cmd.op = OP_WALK_CHK;
      S_LINK_NEW:  cmd.op = OP_LINK_NEW;
      S_LINK_PREV: cmd.op = OP_LINK_PREV;
      S_P_RD:      cmd.op = OP_P_RD;
      S_P_LAT_R:   cmd.op = OP_P_LAT_R;
      S_P_LAT_T:   cmd.op = OP_P_LAT_T;
      S_FREE_R:    cmd.op = OP_FREE_R;
      S_FREE_T:    cmd.op = OP_FREE_T;
      S_EMIT_ACC:  if (stat.out_free) cmd.op = OP_EMIT;
      S_EMIT_FULL: begin
        cmd.st = ST_FULL;
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      S_EMIT_R: begin
        cmd.st   = ST_READY;
        cmd.last = !stat.due;
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      S_EMIT_T: begin
        cmd.st = ST_TIMER;
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      S_EMIT_IDLE: begin
        cmd.st = ST_IDLE;
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* design/rfq_dp.sv */
// ----------------------------------------------------------------------------
// rfq_dp
// slot pool memories, list heads, clock counter and output register
// ----------------------------------------------------------------------------
module rfq_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rfq_pkg::cmd_t                cmd,
  output rfq_pkg::stat_t               stat,
  input  logic [1:0]                   in_type,
  input  logic [rfq_pkg::TASK_W-1:0]   in_handle,
  input  logic [rfq_pkg::TIME_W-1:0]   in_delay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [rfq_pkg::TASK_W-1:0]   out_handle,
  output logic                         out_last
);
  import rfq_pkg::*;

  // list and pool control
  logic [IDX_W-1:0]  free_top_r, ready_first_r, ready_final_r, timer_first_r;
  logic [CNT_W-1:0]  free_count_r, ready_count_r, timer_count_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  init_cnt_r;
  logic              init_done_r;
  // request working registers
  req_t              req_r;
  logic [TASK_W-1:0] handle_r;
  logic [TIME_W-1:0] exp_r;
  logic [IDX_W-1:0]  slot_r, cur_r, prev_r;
  logic              have_prev_r;
  logic [CNT_W-1:0]  k_r;
  logic [IDX_W-1:0]  rnext_r, tnext_r;
  logic [TASK_W-1:0] rtask_r, ttask_r;
  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [TASK_W-1:0] out_handle_r;
  logic              out_last_r;

  logic              out_valid_nxt;
  logic [IDX_W-1:0]  raddr;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr, link_wdata;
  logic [IDX_W-1:0]  link_q;
  logic [TASK_W-1:0] task_q;
  logic [TIME_W-1:0] exp_q;
  logic [TIME_W-1:0] later_diff, due_diff;
  logic              later;
  logic              due;

  always_comb begin
    case (cmd.op)
      OP_TAKE_RD: raddr = free_top_r;
      OP_WALK_RD: raddr = cur_r;
      OP_P_RD:    raddr = ready_first_r;
      default:    raddr = timer_first_r;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_r;
    link_wdata = cur_r;
    case (cmd.op)
      OP_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_cnt_r;
        link_wdata = (init_cnt_r == IDX_W'(POOL_SLOTS - 1)) ? '0 : init_cnt_r + 1'b1;
      end
      OP_TAKE: begin
        link_we    = (req_r == REQ_POST_NOW) && (ready_count_r != '0);
        link_waddr = ready_final_r;
        link_wdata = free_top_r;
      end
      OP_LINK_NEW: link_we = 1'b1;
      OP_LINK_PREV: begin
        link_we    = have_prev_r;
        link_waddr = prev_r;
        link_wdata = slot_r;
      end
      OP_FREE_R: begin
        link_we    = 1'b1;
        link_waddr = ready_first_r;
        link_wdata = free_top_r;
      end
      OP_FREE_T: begin
        link_we    = 1'b1;
        link_waddr = timer_first_r;
        link_wdata = free_top_r;
      end
      default: link_we = 1'b0;
    endcase
  end

  rfq_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(raddr), .rdata(link_q)
  );

  rfq_ram #(.WIDTH(TASK_W), .DEPTH(POOL_SLOTS)) u_task (
    .clk(clk), .we(cmd.op == OP_TAKE), .waddr(free_top_r), .wdata(handle_r),
    .raddr(raddr), .rdata(task_q)
  );

  rfq_ram #(.WIDTH(TIME_W), .DEPTH(POOL_SLOTS)) u_exp (
    .clk(clk), .we((cmd.op == OP_TAKE) && (req_r == REQ_POST_DLY)),
    .waddr(free_top_r), .wdata(exp_r), .raddr(raddr), .rdata(exp_q)
  );

  // wrap aware compare: stored expiry strictly later than the new one
  assign later_diff = exp_q - exp_r;
  assign later      = (later_diff != '0) && !later_diff[TIME_W-1];
  assign due_diff   = now_r - exp_q;
  // head of the timer queue is read by default, so this holds through a poll
  assign due        = (timer_count_r != '0) && !due_diff[TIME_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r    <= '0;
      free_count_r  <= CNT_W'(POOL_SLOTS);
      ready_first_r <= '0;
      ready_final_r <= '0;
      ready_count_r <= '0;
      timer_first_r <= '0;
      timer_count_r <= '0;
      now_r         <= '0;
      init_cnt_r    <= '0;
      init_done_r   <= 1'b0;
    end else begin
      case (cmd.op)
        OP_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == IDX_W'(POOL_SLOTS - 1)) init_done_r <= 1'b1;
        end
        OP_TICK: now_r <= now_r + 1'b1;
        OP_TAKE: begin
          free_top_r   <= link_q;
          free_count_r <= free_count_r - 1'b1;
          if (req_r == REQ_POST_NOW) begin
            if (ready_count_r == '0) ready_first_r <= free_top_r;
            ready_final_r <= free_top_r;
            ready_count_r <= ready_count_r + 1'b1;
          end
        end
        OP_LINK_PREV: begin
          if (!have_prev_r) timer_first_r <= slot_r;
          timer_count_r <= timer_count_r + 1'b1;
        end
        OP_FREE_R: begin
          free_top_r    <= ready_first_r;
          free_count_r  <= free_count_r + 1'b1;
          ready_first_r <= rnext_r;
          ready_count_r <= ready_count_r - 1'b1;
        end
        OP_FREE_T: begin
          free_top_r    <= timer_first_r;
          free_count_r  <= free_count_r + 1'b1;
          timer_first_r <= tnext_r;
          timer_count_r <= timer_count_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        req_r    <= req_t'(in_type);
        handle_r <= in_handle;
        exp_r    <= now_r + in_delay;
      end
      OP_TAKE: begin
        slot_r      <= free_top_r;
        cur_r       <= timer_first_r;
        k_r         <= '0;
        have_prev_r <= 1'b0;
      end
      OP_WALK_CHK: begin
        if (!later) begin
          prev_r      <= cur_r;
          have_prev_r <= 1'b1;
          cur_r       <= link_q;
          k_r         <= k_r + 1'b1;
        end
      end
      OP_P_LAT_R: begin
        rtask_r <= task_q;
        rnext_r <= link_q;
      end
      OP_P_LAT_T: begin
        ttask_r <= task_q;
        tnext_r <= link_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.op == OP_EMIT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_status_r <= cmd.st;
      out_last_r   <= cmd.last;
      case (cmd.st)
        ST_READY: out_handle_r <= rtask_r;
        ST_TIMER: out_handle_r <= ttask_r;
        default:  out_handle_r <= '0;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_handle = out_handle_r;
  assign out_last   = out_last_r;

  assign stat.init_done      = init_done_r;
  assign stat.req            = req_r;
  assign stat.pool_empty     = (free_count_r == '0);
  assign stat.ready_nonempty = (ready_count_r != '0);
  assign stat.walk_end       = (k_r == timer_count_r);
  assign stat.later          = later;
  assign stat.due            = due;
  assign stat.out_free       = !out_valid_r || out_ready;

endmodule

/* design/ready_fifo_and_timer_queue_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// ready_fifo_and_timer_queue_scheduler_unit
// task scheduler with a fifo ready queue and an expiry sorted timer queue
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the link memory is swept to
// chain all 128 slots into the free list before the first request is taken.
// A tick gives no result. A delayed post walks the timer queue through the
// single read port of the slot memories, one entry at a time, and stops at
// the first entry with a later expiry or at the end of the queue. A result
// still waiting at the output holds up the next result until it is taken.
// The result register lets the next request in while the final result still
// waits to be taken.
module ready_fifo_and_timer_queue_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // task_handle[15:0], delay_ms[47:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], out_handle[18:3], zero pad
  output logic        out_tlast
);
  import rfq_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic [2:0] out_status;
  logic [TASK_W-1:0] out_handle;

  rfq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  rfq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_type(in_tuser), .in_handle(in_tdata[15:0]), .in_delay(in_tdata[47:16]),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_status(out_status),
    .out_handle(out_handle), .out_last(out_tlast)
  );

  assign out_tdata = {5'd0, out_handle, out_status};

  a_no_req_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.init_done |-> !in_tready)
    else $error("request taken before free list sweep done");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> stat.out_free)
    else $error("result loaded over a waiting result");

  a_walk_read_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_WALK_CHK |-> $past(cmd.op) == OP_WALK_RD)
    else $error("walk compare without a preceding read");

endmodule

/* tb/sv/rfq_scoreboard.sv */
// ----------------------------------------------------------------------------
// rfq_scoreboard
// watches both streams of the scheduler, keeps a shadow of its queues and
// checks every result against the predicted status, handle and last flag
// ----------------------------------------------------------------------------
module rfq_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // task_handle[15:0], delay_ms[47:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // status[2:0], out_handle[18:3], zero pad
  input  logic        out_tlast,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfq_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [15:0] handle;
    logic        last;
  } disp_t;

  typedef struct {
    logic [15:0] handle;
    logic [31:0] expiry;
  } timer_ent_t;

  disp_t        disp_q[$];
  logic [15:0]  ready_fifo[$];
  timer_ent_t   timer_list[$];
  logic [31:0]  clock_ms;

  assign pending = disp_q.size();

  // wrap-aware: a strictly after b
  function automatic bit after_ms(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != 0 && !d[31];
  endfunction

  task automatic schedule_request(req_t rq, logic [15:0] h, logic [31:0] dly);
    int pos;
    int n;
    timer_ent_t e;
    disp_t d;
    n = 0;
    if (rq == REQ_POST_NOW || rq == REQ_POST_DLY) begin
      if (ready_fifo.size() + timer_list.size() >= POOL_SLOTS) begin
        disp_q.push_back('{ST_FULL, 16'd0, 1'b1});
      end else begin
        if (rq == REQ_POST_NOW) begin
          ready_fifo.push_back(h);
        end else begin
          e.handle = h;
          e.expiry = clock_ms + dly;
          pos = 0;
          while (pos < timer_list.size() && !after_ms(timer_list[pos].expiry, e.expiry))
            pos++;
          timer_list.insert(pos, e);
        end
        disp_q.push_back('{ST_ACCEPT, 16'd0, 1'b1});
      end
    end else if (rq == REQ_TICK) begin
      clock_ms++;
    end else begin
      if (ready_fifo.size() > 0) begin
        disp_q.push_back('{ST_READY, ready_fifo.pop_front(), 1'b0});
        n++;
      end
      if (timer_list.size() > 0 && !(clock_ms - timer_list[0].expiry >> 31)) begin
        e = timer_list.pop_front();
        disp_q.push_back('{ST_TIMER, e.handle, 1'b0});
        n++;
      end
      if (n == 0) begin
        disp_q.push_back('{ST_IDLE, 16'd0, 1'b1});
      end else begin
        d = disp_q.pop_back();
        d.last = 1'b1;
        disp_q.push_back(d);
      end
    end
  endtask

  always @(posedge clk) begin
    disp_t got;
    disp_t want;
    if (!rst_n) begin
      disp_q.delete();
      ready_fifo.delete();
      timer_list.delete();
      clock_ms = '0;
      err_count <= 0;
    end else begin
      // result first: a request accepted this edge cannot yet have a result
      if (out_tvalid && out_tready) begin
        got = '{status_t'(out_tdata[2:0]), out_tdata[18:3], out_tlast};
        if (disp_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          err_count <= err_count + 1;
        end else begin
          want = disp_q.pop_front();
          if (got !== want || out_tdata[23:19] !== 5'd0) begin
            $display("%0t mismatch: expected st=%0d h=%h last=%b, actual st=%0d h=%h last=%b",
                     $time, want.st, want.handle, want.last,
                     out_tdata[2:0], out_tdata[18:3], out_tlast);
            err_count <= err_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        schedule_request(req_t'(in_tuser), in_tdata[15:0], in_tdata[47:16]);
    end
  end
endmodule

/* tb/sv/ready_fifo_and_timer_queue_scheduler_unit_tb.sv */
// ----------------------------------------------------------------------------
// ready_fifo_and_timer_queue_scheduler_unit_tb
// drives posts, ticks and polls with random gaps and back-pressure; a
// scoreboard beside the block predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module ready_fifo_and_timer_queue_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfq_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  int          err_count;
  int          pending;
  bit          calm = 1'b0;
  int          quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ready_fifo_and_timer_queue_scheduler_unit dut (.*);

  rfq_scoreboard scb (.*);

  // sink back-pressure in bursts of random length
  always @(posedge clk) begin
    int hold;
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      hold = $urandom_range(1, 3);
      out_tready <= 1'b0;
      repeat (hold) @(posedge clk);
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(req_t rq, logic [15:0] h, logic [31:0] dly);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq;
    in_tdata  <= {dly, h};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_request(int flavor);
    int r;
    logic [31:0] dly;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: dly = $urandom();
      1: dly = 32'hFFFF_FFFF - $urandom_range(0, 4);
      default: dly = $urandom_range(0, 6);
    endcase
    if (flavor == 0) begin
      if (r < 25) send_request(REQ_POST_NOW, $urandom(), dly);
      else if (r < 50) send_request(REQ_POST_DLY, $urandom(), dly);
      else if (r < 70) send_request(REQ_TICK, $urandom(), $urandom());
      else send_request(REQ_POLL, $urandom(), $urandom());
    end else begin
      // fill-heavy mix to hit pool exhaustion
      if (r < 45) send_request(REQ_POST_NOW, $urandom(), dly);
      else if (r < 90) send_request(REQ_POST_DLY, $urandom(), dly);
      else send_request(REQ_POLL, $urandom(), $urandom());
    end
  endtask

  initial begin
    int settle;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, equal expiry, idle poll, wrap
    send_request(REQ_POLL, 16'h0000, 32'h0);
    send_request(REQ_POST_NOW, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_POST_NOW, 16'h0000, 32'h0);
    send_request(REQ_POST_DLY, 16'hA5A5, 32'd0);
    send_request(REQ_POST_DLY, 16'h5A5A, 32'd0);
    send_request(REQ_POST_DLY, 16'h1234, 32'd2);
    send_request(REQ_POST_DLY, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_POST_DLY, 16'h0001, 32'h8000_0000);
    send_request(REQ_POLL, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_POLL, 16'h0, 32'h0);
    send_request(REQ_POLL, 16'h0, 32'h0);
    send_request(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(REQ_TICK, 16'h0, 32'h0);
    send_request(REQ_POLL, 16'h0, 32'h0);
    send_request(REQ_POLL, 16'h0, 32'h0);
    send_request(REQ_POLL, 16'h0, 32'h0);
    // hold off until every result has come
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < 1000; i++) random_request(0);
    for (int i = 0; i < 300; i++) random_request(1);
    for (int i = 0; i < 500; i++) random_request(0);
    calm = 1'b1;
    for (int i = 0; i < 100; i++) random_request(0);
    in_tvalid <= 1'b0;
    @(posedge clk);
    settle = 0;
    while (pending != 0 && settle < WATCHDOG) begin
      @(posedge clk);
      settle++;
    end
    repeat (300) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
